// ===== hw/rtl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers for the Intel HEX record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

  localparam int ADDR_BITS = 16;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SYNTAX    = 2'd0,
    ERR_DISCONTIG = 2'd1,
    ERR_CHECKSUM  = 2'd2
  } err_t;

  typedef enum logic {
    ACT_CHAR = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_BITS-1:0]  address;
    logic [7:0]            data_byte;
    err_t                  error_code;
    logic [ADDR_BITS-1:0]  length;
  } result_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/intel_hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Decodes a stream of Intel HEX characters into addressed data bytes.
// ----------------------------------------------------------------------------
// Takes one character request per cycle. Each accepted request sits in an
// input register while it is decoded against the record state, and its
// result is written from there into the queue, from which it is offered.
// Results go into a two-entry queue. With the output draining, requests flow
// every cycle. The input stalls while the queued results plus the request in
// flight could reach three. So with one result waiting on a stalled output, a
// request is taken only while none is in flight, and none is taken once two
// results wait.
// Data bytes are emitted as decoded, before their record checksum is checked.
// Any error is reported once and then all requests, end of input included,
// are consumed silently until reset. An end request outside a record reports
// start address and length and resets the parser; in a record it is a syntax error.
`default_nettype none

module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic                 action,
  input  wire logic [7:0]           char_byte,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [1:0]                kind,
  output logic [ADDR_BITS-1:0]      address,
  output logic [7:0]                data_byte,
  output logic [1:0]                error_code,
  output logic [ADDR_BITS-1:0]      length
);

  typedef enum logic [2:0] {
    PH_COLON,
    PH_RECORD,
    PH_SKIP,
    PH_ERROR
  } phase_t;

  // input register
  logic        st_valid;
  logic        st_action;
  logic [7:0]  st_char;

  // record state
  phase_t                phase, phase_next;
  logic [9:0]            digit_index, digit_index_next;
  logic [7:0]            byte_count, byte_count_next;
  logic [7:0]            record_type, record_type_next;
  logic [ADDR_BITS-1:0]  record_address, record_address_next;
  logic [7:0]            running_sum, running_sum_next;
  logic [3:0]            high_nibble, high_nibble_next;
  logic [ADDR_BITS-1:0]  next_address, next_address_next;
  logic [ADDR_BITS-1:0]  start_address, start_address_next;
  logic                  have_start, have_start_next;
  logic                  error_latched, error_latched_next;

  // result queue
  result_t     q_entry [2];
  logic        q_wr, q_rd;
  logic [1:0]  q_count;

  logic        res_valid;
  result_t     res;
  logic        push, pop, accept;
  logic [2:0]  occupancy;

  logic [4:0]  hex;
  logic [7:0]  b;
  logic [7:0]  sum_b;
  logic [8:0]  k;
  logic [8:0]  body_end;

  assign hex      = hex_value(st_char);
  assign b        = {high_nibble, hex[3:0]};
  assign sum_b    = running_sum + b;
  assign k        = digit_index[9:1];
  assign body_end = {1'b0, byte_count} + 9'd4;

  always_comb begin
    phase_next          = phase;
    digit_index_next    = digit_index;
    byte_count_next     = byte_count;
    record_type_next    = record_type;
    record_address_next = record_address;
    running_sum_next    = running_sum;
    high_nibble_next    = high_nibble;
    next_address_next   = next_address;
    start_address_next  = start_address;
    have_start_next     = have_start;
    error_latched_next  = error_latched;
    res_valid           = 1'b0;
    res                 = '0;

    if (st_valid && !error_latched && phase != PH_ERROR) begin
      if (st_action == ACT_END) begin
        if (phase == PH_RECORD) begin
          phase_next         = PH_ERROR;
          error_latched_next = 1'b1;
          res_valid          = 1'b1;
          res.kind           = KIND_ERROR;
          res.error_code     = ERR_SYNTAX;
        end else begin
          res_valid           = 1'b1;
          res.kind            = KIND_END;
          res.address         = start_address;
          res.length          = next_address - start_address;
          phase_next          = PH_COLON;
          digit_index_next    = '0;
          byte_count_next     = '0;
          record_type_next    = '0;
          record_address_next = '0;
          running_sum_next    = '0;
          high_nibble_next    = '0;
          next_address_next   = '0;
          start_address_next  = '0;
          have_start_next     = 1'b0;
        end
      end else begin
        case (phase)
          PH_COLON: begin
            if (st_char != CHAR_COLON) begin
              phase_next         = PH_ERROR;
              error_latched_next = 1'b1;
              res_valid          = 1'b1;
              res.kind           = KIND_ERROR;
              res.error_code     = ERR_SYNTAX;
            end else begin
              phase_next          = PH_RECORD;
              digit_index_next    = '0;
              byte_count_next     = '0;
              record_type_next    = '0;
              record_address_next = '0;
              running_sum_next    = '0;
              high_nibble_next    = '0;
            end
          end
          PH_SKIP: begin
            if (st_char == CHAR_LF) begin
              phase_next = PH_COLON;
            end
          end
          PH_RECORD: begin
            if (!hex[4]) begin
              phase_next         = PH_ERROR;
              error_latched_next = 1'b1;
              res_valid          = 1'b1;
              res.kind           = KIND_ERROR;
              res.error_code     = ERR_SYNTAX;
            end else if (!digit_index[0]) begin
              high_nibble_next = hex[3:0];
              digit_index_next = digit_index + 10'd1;
            end else begin
              digit_index_next = digit_index + 10'd1;
              if (k[8:2] == '0) begin
                running_sum_next = sum_b;
                case (k[1:0])
                  2'd0: byte_count_next = b;
                  2'd1: record_address_next = {b, 8'h00};
                  2'd2: record_address_next = {record_address[ADDR_BITS-1:8], b};
                  default: begin
                    record_type_next = b;
                    if (!have_start) begin
                      have_start_next    = 1'b1;
                      start_address_next = record_address;
                      next_address_next  = record_address;
                    end else if (b == 8'h00 && record_address != next_address) begin
                      phase_next         = PH_ERROR;
                      error_latched_next = 1'b1;
                      res_valid          = 1'b1;
                      res.kind           = KIND_ERROR;
                      res.error_code     = ERR_DISCONTIG;
                    end
                    if (b != 8'h00) begin
                      phase_next = PH_SKIP;
                    end
                  end
                endcase
              end else if (k < body_end) begin
                running_sum_next  = sum_b;
                next_address_next = next_address + ADDR_BITS'(1);
                res_valid         = 1'b1;
                res.kind          = KIND_DATA;
                res.address       = next_address;
                res.data_byte     = b;
              end else begin
                running_sum_next = sum_b;
                if (sum_b != 8'h00) begin
                  phase_next         = PH_ERROR;
                  error_latched_next = 1'b1;
                  res_valid          = 1'b1;
                  res.kind           = KIND_ERROR;
                  res.error_code     = ERR_CHECKSUM;
                end else begin
                  phase_next = PH_SKIP;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign push       = res_valid;
  assign pop        = result_valid && !result_stall;
  assign occupancy  = {1'b0, q_count} + {2'b00, st_valid} - {2'b00, pop};
  assign item_stall = occupancy >= 3'd2;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid       <= 1'b0;
      phase          <= PH_COLON;
      digit_index    <= '0;
      byte_count     <= '0;
      record_type    <= '0;
      record_address <= '0;
      running_sum    <= '0;
      high_nibble    <= '0;
      next_address   <= '0;
      start_address  <= '0;
      have_start     <= 1'b0;
      error_latched  <= 1'b0;
      q_wr           <= 1'b0;
      q_rd           <= 1'b0;
      q_count        <= '0;
    end else begin
      st_valid       <= accept;
      phase          <= phase_next;
      digit_index    <= digit_index_next;
      byte_count     <= byte_count_next;
      record_type    <= record_type_next;
      record_address <= record_address_next;
      running_sum    <= running_sum_next;
      high_nibble    <= high_nibble_next;
      next_address   <= next_address_next;
      start_address  <= start_address_next;
      have_start     <= have_start_next;
      error_latched  <= error_latched_next;
      if (push) begin
        q_wr <= ~q_wr;
      end
      if (pop) begin
        q_rd <= ~q_rd;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
    if (accept) begin
      st_action <= action;
      st_char   <= char_byte;
    end
    if (push) begin
      q_entry[q_wr] <= res;
    end
  end

  assign result_valid = q_count != 2'd0;
  assign kind         = q_entry[q_rd].kind;
  assign address      = q_entry[q_rd].address;
  assign data_byte    = q_entry[q_rd].data_byte;
  assign error_code   = q_entry[q_rd].error_code;
  assign length       = q_entry[q_rd].length;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, q_count} + {2'b00, st_valid}) <= 3'd2)
    else $error("result queue plus request in flight exceeds two");

  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> !res_valid)
    else $error("result produced after latched error");

  a_error_phase: assert property (@(posedge clk) disable iff (rst)
    error_latched == (phase == PH_ERROR))
    else $error("error flag and phase disagree");

  a_data_in_record: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_DATA) |-> (phase == PH_RECORD && have_start))
    else $error("data byte outside a started record");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("error flag cleared without reset");

endmodule

`default_nettype wire

// ===== dv/intel_hex_record_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// intel_hex_record_parser_tb
// Streams Intel HEX text into the parser one character request at a time and
// checks each result, field by field, against a record decoder kept in the
// bench. Runs directed corner records, long random files with junk after
// checksums, output back-pressure, and finally one fault that must latch.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_tb;
  import ihex_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 30;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  typedef enum logic [1:0] {WAIT_COLON, IN_RECORD, SKIP_LINE, DEAD} line_phase_t;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum int {
    BAD_LINE_START, SHORT_HEADER, BAD_BODY_DIGIT, END_IN_RECORD, GAP_IN_ADDRESS, BAD_CHECKSUM
  } fault_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic                 action;
  logic [7:0]           char_byte;
  logic                 result_valid;
  logic                 result_stall;
  logic [1:0]           kind;
  logic [ADDR_BITS-1:0] address;
  logic [7:0]           data_byte;
  logic [1:0]           error_code;
  logic [ADDR_BITS-1:0] length;

  bit idle_on;
  bit hold_off;
  int cycle_count = 0;
  int mismatches = 0;
  int live_items = 0;
  int records_sent = 0;
  int data_seen = 0;
  int summaries_seen = 0;
  int errors_seen = 0;
  fault_t closing_fault;

  // decoder state
  line_phase_t          ln_phase;
  int                   digit_idx;
  logic [7:0]           rec_count;
  logic [7:0]           rec_type;
  logic [7:0]           rec_sum;
  logic [3:0]           hi_nib;
  logic [ADDR_BITS-1:0] rec_addr;
  logic [ADDR_BITS-1:0] run_addr;
  logic [ADDR_BITS-1:0] file_start;
  bit                   start_known;
  result_t              awaited_results[$];

  intel_hex_record_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .char_byte    (char_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .address      (address),
    .data_byte    (data_byte),
    .error_code   (error_code),
    .length       (length)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("intel_hex_record_parser_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= hold_off || (idle_on && $urandom_range(99) < 11);
  end

  function automatic void clear_file_state();
    ln_phase    = WAIT_COLON;
    digit_idx   = 0;
    rec_count   = '0;
    rec_type    = '0;
    rec_sum     = '0;
    hi_nib      = '0;
    rec_addr    = '0;
    run_addr    = '0;
    file_start  = '0;
    start_known = 1'b0;
  endfunction

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h37;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h57;
    return -1;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n, bit upper);
    if (n < 10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (nibble_of(c) >= 0);
    return c;
  endfunction

  function automatic void raise_error(err_t code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    awaited_results.push_back(r);
    ln_phase = DEAD;
  endfunction

  function automatic void decode_request(action_t act, logic [7:0] c);
    result_t    r;
    int         nib;
    int         k;
    logic [7:0] b;
    r = '0;
    if (ln_phase == DEAD) return;
    if (act == ACT_END) begin
      if (ln_phase == IN_RECORD) begin
        raise_error(ERR_SYNTAX);
      end else begin
        r.kind    = KIND_END;
        r.address = file_start;
        r.length  = run_addr - file_start;
        awaited_results.push_back(r);
        clear_file_state();
      end
      return;
    end
    case (ln_phase)
      WAIT_COLON: begin
        if (c != CHAR_COLON) begin
          raise_error(ERR_SYNTAX);
        end else begin
          ln_phase  = IN_RECORD;
          digit_idx = 0;
          rec_count = '0;
          rec_type  = '0;
          rec_addr  = '0;
          rec_sum   = '0;
          hi_nib    = '0;
        end
      end
      SKIP_LINE: begin
        if (c == CHAR_LF) ln_phase = WAIT_COLON;
      end
      default: begin
        nib = nibble_of(c);
        if (nib < 0) begin
          raise_error(ERR_SYNTAX);
        end else if (digit_idx % 2 == 0) begin
          hi_nib = nib[3:0];
          digit_idx++;
        end else begin
          b = {hi_nib, nib[3:0]};
          k = digit_idx / 2;
          digit_idx++;
          rec_sum = rec_sum + b;
          if (k == 0) begin
            rec_count = b;
          end else if (k == 1) begin
            rec_addr = {b, 8'h00};
          end else if (k == 2) begin
            rec_addr[7:0] = b;
          end else if (k == 3) begin
            rec_type = b;
            if (!start_known) begin
              start_known = 1'b1;
              file_start  = rec_addr;
              run_addr    = rec_addr;
            end else if (b == REC_DATA && rec_addr != run_addr) begin
              raise_error(ERR_DISCONTIG);
              return;
            end
            if (b != REC_DATA) ln_phase = SKIP_LINE;
          end else if (k < 4 + rec_count) begin
            r.kind      = KIND_DATA;
            r.address   = run_addr;
            r.data_byte = b;
            awaited_results.push_back(r);
            run_addr++;
          end else if (rec_sum != 0) begin
            raise_error(ERR_CHECKSUM);
          end else begin
            ln_phase = SKIP_LINE;
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing pending", kind));
      end else begin
        want = awaited_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (address !== want.address)
          report_mismatch($sformatf("address %h, want %h", address, want.address));
        if (data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %h, want %h", data_byte, want.data_byte));
        if (error_code !== want.error_code)
          report_mismatch($sformatf("error_code %0d, want %0d", error_code, want.error_code));
        if (length !== want.length)
          report_mismatch($sformatf("length %h, want %h", length, want.length));
        case (want.kind)
          KIND_DATA: data_seen++;
          KIND_END:  summaries_seen++;
          default:   errors_seen++;
        endcase
      end
    end
  end

  task automatic send_item(action_t act, logic [7:0] c);
    while (idle_on && $urandom_range(99) < 11) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    char_byte  <= c;
    do @(posedge clk); while (item_stall);
    if (ln_phase != DEAD) live_items++;
    decode_request(act, c);
  endtask

  task automatic send_hex_byte(logic [7:0] b);
    send_item(ACT_CHAR, hex_digit(b[7:4], $urandom_range(1)));
    send_item(ACT_CHAR, hex_digit(b[3:0], $urandom_range(1)));
  endtask

  // optional junk after the checksum, optional CR, then LF
  task automatic end_line();
    int         n;
    logic [7:0] c;
    n = ($urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
    repeat (n) begin
      c = 8'($urandom_range(255));
      if (c == CHAR_LF) c = CHAR_CR;
      send_item(ACT_CHAR, c);
    end
    if ($urandom_range(1)) send_item(ACT_CHAR, CHAR_CR);
    send_item(ACT_CHAR, CHAR_LF);
  endtask

  task automatic send_record(logic [7:0] rtype, logic [ADDR_BITS-1:0] addr, int nbytes,
                             fill_t fill, logic [7:0] sum_skew);
    logic [7:0] sum;
    logic [7:0] b;
    records_sent++;
    sum = 8'(nbytes) + addr[15:8] + addr[7:0] + rtype;
    send_item(ACT_CHAR, CHAR_COLON);
    send_hex_byte(8'(nbytes));
    send_hex_byte(addr[15:8]);
    send_hex_byte(addr[7:0]);
    send_hex_byte(rtype);
    for (int i = 0; i < nbytes; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(255));
      endcase
      sum = sum + b;
      send_hex_byte(b);
    end
    send_hex_byte((~sum + 8'd1) + sum_skew);
    end_line();
  endtask

  task automatic test_empty_file();
    send_item(ACT_END, 8'h00);
  endtask

  // two bytes from 0xFFFF wrap the running address, then an EOF record
  task automatic test_wrapping_record();
    send_record(REC_DATA, 16'hFFFF, 2, FILL_ONES, 8'h00);
    send_record(REC_EOF, 16'h0000, 0, FILL_ZERO, 8'h00);
    send_item(ACT_END, 8'hFF);
  endtask

  task automatic test_random_files(int target);
    int                   pick;
    int                   nbytes;
    logic [7:0]           rtype;
    logic [ADDR_BITS-1:0] addr;
    while (live_items < target) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(ACT_END, 8'($urandom_range(255)));
      end else begin
        rtype = (pick < 80) ? REC_DATA : 8'($urandom_range(1, 255));
        pick = $urandom_range(199);
        nbytes = (pick == 0) ? 255 : (pick < 20) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        if (start_known && rtype == REC_DATA) addr = run_addr;
        else if ($urandom_range(3) == 0) addr = 16'hFFF0 | 16'($urandom_range(15));
        else addr = 16'($urandom_range(65535));
        send_record(rtype, addr, nbytes, FILL_RANDOM, 8'h00);
      end
    end
  endtask

  // receiver holds off while a full-size record keeps coming
  task automatic test_backpressure();
    logic [ADDR_BITS-1:0] addr;
    addr = start_known ? run_addr : 16'h8000;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      send_record(REC_DATA, addr, 255, FILL_RANDOM, 8'h00);
    join
  endtask

  task automatic test_error_latch();
    int                   n;
    logic [7:0]           c;
    logic [ADDR_BITS-1:0] addr;
    closing_fault = fault_t'($urandom_range(BAD_CHECKSUM));
    case (closing_fault)
      BAD_LINE_START: begin
        case ($urandom_range(2))
          0: c = CHAR_LF;
          1: c = CHAR_CR;
          default: do c = 8'($urandom_range(255)); while (c == CHAR_COLON);
        endcase
        send_item(ACT_CHAR, c);
      end
      SHORT_HEADER, END_IN_RECORD: begin
        send_item(ACT_CHAR, CHAR_COLON);
        repeat ($urandom_range(7))
          send_item(ACT_CHAR, hex_digit(4'($urandom_range(15)), $urandom_range(1)));
        if (closing_fault == SHORT_HEADER) send_item(ACT_CHAR, pick_non_hex());
        else send_item(ACT_END, 8'($urandom_range(255)));
      end
      BAD_BODY_DIGIT: begin
        n = $urandom_range(1, 8);
        addr = start_known ? run_addr : 16'($urandom_range(65535));
        send_item(ACT_CHAR, CHAR_COLON);
        send_hex_byte(8'(n));
        send_hex_byte(addr[15:8]);
        send_hex_byte(addr[7:0]);
        send_hex_byte(REC_DATA);
        repeat ($urandom_range(n)) send_hex_byte(8'($urandom_range(255)));
        if ($urandom_range(1))
          send_item(ACT_CHAR, hex_digit(4'($urandom_range(15)), $urandom_range(1)));
        send_item(ACT_CHAR, pick_non_hex());
      end
      GAP_IN_ADDRESS: begin
        if (!start_known)
          send_record(REC_EOF, 16'($urandom_range(65535)), 0, FILL_ZERO, 8'h00);
        send_record(REC_DATA, run_addr + 16'($urandom_range(1, 65535)), $urandom_range(4),
                    FILL_RANDOM, 8'h00);
      end
      default: begin
        send_record(REC_DATA, start_known ? run_addr : 16'h0100, $urandom_range(1, 8),
                    FILL_RANDOM, 8'($urandom_range(1, 255)));
      end
    endcase
    // all of this must be swallowed silently
    repeat (40)
      send_item(($urandom_range(7) == 0) ? ACT_END : ACT_CHAR, 8'($urandom_range(255)));
  endtask

  initial begin
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    action       <= ACT_CHAR;
    char_byte    <= 8'h00;
    result_stall <= 1'b0;
    idle_on      <= 1'b1;
    hold_off     <= 1'b0;
    clear_file_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_file();
    test_wrapping_record();
    test_random_files(700);
    idle_on <= 1'b0;
    test_random_files(1100);
    idle_on <= 1'b1;
    test_random_files(1400);
    test_backpressure();
    test_error_latch();

    item_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d decoded requests in %0d records: %0d data bytes, %0d summaries",
             live_items, records_sent, data_seen, summaries_seen);
    $display("closing fault %s gave %0d latched error(s), then ignored traffic",
             closing_fault.name(), errors_seen);
    if (mismatches == 0) begin
      $display("intel_hex_record_parser_tb: PASS");
    end else begin
      $display("intel_hex_record_parser_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ihex_pkg.sv
hw/rtl/intel_hex_record_parser.sv
dv/intel_hex_record_parser_tb.sv
